// ----- design/qsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// qsbs_pkg
// Shared constants, command and status types for the quicksort block sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package qsbs_pkg;

    localparam int MAX_ITEMS_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Element store read address select
    typedef logic [1:0] addr_sel_t;
    localparam addr_sel_t ADDR_I     = 2'd0;
    localparam addr_sel_t ADDR_J     = 2'd1;
    localparam addr_sel_t ADDR_FIRST = 2'd2;
    localparam addr_sel_t ADDR_K     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_wr;     // input word accepted: store or flag overflow
        logic      cnt_clr;     // block done: clear count and overflow flag
        logic      push_init;   // push the whole block range
        logic      pop;         // pop one range
        logic      latch_range; // take popped range into first/last
        logic      latch_piv;   // take pivot, set i/j to range ends
        logic      i_inc;
        logic      j_dec;
        logic      latch_vi;
        logic      latch_vj;
        logic      wr_i;        // store[i] <= value at j
        logic      wr_j;        // store[j] <= value at i
        logic      wr_first;    // store[first] <= value at j
        logic      wr_jpiv;     // store[j] <= pivot
        logic      push_l;
        logic      push_r;
        logic      k_clr;
        logic      k_inc;
        logic      out_load;
        addr_sel_t addr_sel;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic n_lt2;
        logic sp_zero;
        logic range_bad;
        logic i_adv;
        logic j_adv;
        logic i_lt_j;
        logic push_l_ok;
        logic push_r_ok;
        logic k_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- design/qsbs_dpath.sv -----
// ----------------------------------------------------------------------------
// qsbs_dpath
// Element store, range stack, partition indices and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsbs_dpath #(
    parameter int MAX_ITEMS   = qsbs_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = qsbs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire qsbs_pkg::cmd_t         cmd,
    output qsbs_pkg::sts_t              sts,
    input  wire logic [VALUE_WIDTH-1:0] in_value,
    input  wire logic                   m_ready,
    output logic                        out_valid,
    output logic [VALUE_WIDTH-1:0]      out_value,
    output logic                        out_last,
    output logic                        out_ovf
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int RNG_W = 2 * IDX_W;

    logic [VALUE_WIDTH-1:0] elem_mem  [MAX_ITEMS];
    logic [RNG_W-1:0]       stack_mem [MAX_ITEMS];

    logic [CNT_W-1:0]       cnt_reg;
    logic                   ovf_reg;
    logic [CNT_W-1:0]       sp_reg;
    logic [IDX_W-1:0]       first_reg, last_reg, i_reg, j_reg, k_reg;
    logic [VALUE_WIDTH-1:0] piv_reg, vi_reg, vj_reg, rd_data_reg;
    logic [RNG_W-1:0]       stk_rd_reg;
    logic                   out_valid_reg, out_last_reg, out_ovf_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;

    logic                   full;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa, mem_ra;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic                   stk_we;
    logic [RNG_W-1:0]       stk_wd;
    logic [IDX_W-1:0]       stk_rd_idx;
    logic [IDX_W-1:0]       stk_lo, stk_hi;
    logic                   sp_room;

    assign full       = (cnt_reg == CNT_W'(MAX_ITEMS));
    assign stk_rd_idx = IDX_W'(sp_reg - CNT_W'(1));
    assign stk_lo     = stk_rd_reg[RNG_W-1:IDX_W];
    assign stk_hi     = stk_rd_reg[IDX_W-1:0];
    assign sp_room    = (sp_reg < CNT_W'(MAX_ITEMS));

    // Element store write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = i_reg;
        mem_wd = vj_reg;
        if (cmd.load_wr && !full) begin
            mem_we = 1'b1;
            mem_wa = cnt_reg[IDX_W-1:0];
            mem_wd = in_value;
        end else if (cmd.wr_i) begin
            mem_we = 1'b1;
            mem_wa = i_reg;
            mem_wd = vj_reg;
        end else if (cmd.wr_j) begin
            mem_we = 1'b1;
            mem_wa = j_reg;
            mem_wd = vi_reg;
        end else if (cmd.wr_first) begin
            mem_we = 1'b1;
            mem_wa = first_reg;
            mem_wd = vj_reg;
        end else if (cmd.wr_jpiv) begin
            mem_we = 1'b1;
            mem_wa = j_reg;
            mem_wd = piv_reg;
        end
    end

    // Element store read port
    always_comb begin
        case (cmd.addr_sel)
            qsbs_pkg::ADDR_I:     mem_ra = i_reg;
            qsbs_pkg::ADDR_J:     mem_ra = j_reg;
            qsbs_pkg::ADDR_FIRST: mem_ra = first_reg;
            qsbs_pkg::ADDR_K:     mem_ra = k_reg;
            default:              mem_ra = i_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            elem_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= elem_mem[mem_ra];
    end

    // Range stack: entry is {lo, hi}
    always_comb begin
        stk_we = cmd.push_init | cmd.push_l | cmd.push_r;
        stk_wd = {first_reg, IDX_W'(j_reg - IDX_W'(1))};
        if (cmd.push_init) begin
            stk_wd = {IDX_W'(0), IDX_W'(cnt_reg - CNT_W'(1))};
        end else if (cmd.push_r) begin
            stk_wd = {IDX_W'(j_reg + IDX_W'(1)), last_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[sp_reg[IDX_W-1:0]] <= stk_wd;
        end
        stk_rd_reg <= stack_mem[stk_rd_idx];
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sp_reg  <= '0;
        end else begin
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end else if (cmd.load_wr) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (stk_we) begin
                sp_reg <= sp_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                sp_reg <= sp_reg - CNT_W'(1);
            end
        end
    end

    // Partition indices and held values
    always_ff @(posedge aclk) begin
        if (cmd.latch_range) begin
            first_reg <= stk_lo;
            last_reg  <= stk_hi;
        end
        if (cmd.latch_piv) begin
            piv_reg <= rd_data_reg;
            i_reg   <= first_reg;
            j_reg   <= last_reg;
        end else begin
            if (cmd.i_inc) begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (cmd.j_dec) begin
                j_reg <= j_reg - IDX_W'(1);
            end
        end
        if (cmd.latch_vi) begin
            vi_reg <= rd_data_reg;
        end
        if (cmd.latch_vj) begin
            vj_reg <= rd_data_reg;
        end
        if (cmd.k_clr) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + IDX_W'(1);
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= sts.k_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    // Status
    always_comb begin
        sts.n_lt2     = (cnt_reg < CNT_W'(2));
        sts.sp_zero   = (sp_reg == '0);
        sts.range_bad = (stk_lo >= stk_hi) || (CNT_W'(stk_hi) >= CNT_W'(MAX_ITEMS));
        sts.i_adv     = ($signed(rd_data_reg) <= $signed(piv_reg)) && (i_reg < last_reg);
        sts.j_adv     = ($signed(rd_data_reg) > $signed(piv_reg)) && (j_reg > first_reg);
        sts.i_lt_j    = (i_reg < j_reg);
        sts.push_l_ok = (CNT_W'(j_reg) > CNT_W'(first_reg) + CNT_W'(1)) && sp_room;
        sts.push_r_ok = (CNT_W'(j_reg) + CNT_W'(1) < CNT_W'(last_reg)) && sp_room;
        sts.k_last    = (CNT_W'(k_reg) == cnt_reg - CNT_W'(1));
        sts.out_free  = !out_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

// ----- design/qsbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// qsbs_ctrl
// Sequencer for load, quicksort partition passes and sorted emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qsbs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_last,
    output logic                s_ready,
    input  wire qsbs_pkg::sts_t sts,
    output qsbs_pkg::cmd_t      cmd
);

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_POP   = 5'd2;
    localparam logic [4:0] S_POPW  = 5'd3;
    localparam logic [4:0] S_PIVR  = 5'd4;
    localparam logic [4:0] S_PIVL  = 5'd5;
    localparam logic [4:0] S_OUTER = 5'd6;
    localparam logic [4:0] S_RDI   = 5'd7;
    localparam logic [4:0] S_CHKI  = 5'd8;
    localparam logic [4:0] S_RDJ   = 5'd9;
    localparam logic [4:0] S_CHKJ  = 5'd10;
    localparam logic [4:0] S_SWI   = 5'd11;
    localparam logic [4:0] S_SWJ   = 5'd12;
    localparam logic [4:0] S_FINA  = 5'd13;
    localparam logic [4:0] S_FINB  = 5'd14;
    localparam logic [4:0] S_PUSHL = 5'd15;
    localparam logic [4:0] S_PUSHR = 5'd16;
    localparam logic [4:0] S_EMRD  = 5'd17;
    localparam logic [4:0] S_EMLD  = 5'd18;

    logic [4:0] state_reg, state_next;

    assign s_ready = (state_reg == S_LOAD);

    always_comb begin
        cmd        = '0;
        cmd.addr_sel = qsbs_pkg::ADDR_I;
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.load_wr = 1'b1;
                    if (s_last) begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.k_clr = 1'b1;
                if (sts.n_lt2) begin
                    state_next = S_EMRD;
                end else begin
                    cmd.push_init = 1'b1;
                    state_next    = S_POP;
                end
            end
            S_POP: begin
                if (sts.sp_zero) begin
                    state_next = S_EMRD;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW: begin
                cmd.latch_range = 1'b1;
                state_next      = sts.range_bad ? S_POP : S_PIVR;
            end
            S_PIVR: begin
                cmd.addr_sel = qsbs_pkg::ADDR_FIRST;
                state_next   = S_PIVL;
            end
            S_PIVL: begin
                cmd.latch_piv = 1'b1;
                state_next    = S_OUTER;
            end
            S_OUTER: begin
                state_next = sts.i_lt_j ? S_RDI : S_FINA;
            end
            S_RDI: begin
                cmd.addr_sel = qsbs_pkg::ADDR_I;
                state_next   = S_CHKI;
            end
            S_CHKI: begin
                cmd.latch_vi = 1'b1;
                if (sts.i_adv) begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_RDI;
                end else begin
                    state_next = S_RDJ;
                end
            end
            S_RDJ: begin
                cmd.addr_sel = qsbs_pkg::ADDR_J;
                state_next   = S_CHKJ;
            end
            S_CHKJ: begin
                cmd.latch_vj = 1'b1;
                if (sts.j_adv) begin
                    cmd.j_dec  = 1'b1;
                    state_next = S_RDJ;
                end else if (sts.i_lt_j) begin
                    state_next = S_SWI;
                end else begin
                    state_next = S_FINA;
                end
            end
            S_SWI: begin
                cmd.wr_i   = 1'b1;
                state_next = S_SWJ;
            end
            S_SWJ: begin
                cmd.wr_j   = 1'b1;
                state_next = S_OUTER;
            end
            S_FINA: begin
                cmd.wr_first = 1'b1;
                state_next   = S_FINB;
            end
            S_FINB: begin
                cmd.wr_jpiv = 1'b1;
                state_next  = S_PUSHL;
            end
            S_PUSHL: begin
                cmd.push_l = sts.push_l_ok;
                state_next = S_PUSHR;
            end
            S_PUSHR: begin
                cmd.push_r = sts.push_r_ok;
                state_next = S_POP;
            end
            S_EMRD: begin
                cmd.addr_sel = qsbs_pkg::ADDR_K;
                state_next   = S_EMLD;
            end
            S_EMLD: begin
                cmd.addr_sel = qsbs_pkg::ADDR_K;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.k_last) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_LOAD;
                    end else begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_EMRD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/quicksort_block_sorter_core.sv -----
// ----------------------------------------------------------------------------
// quicksort_block_sorter_core
// Collects a block of signed words, sorts it ascending, streams it back out.
// ----------------------------------------------------------------------------
// Usage:
//   Send a block of signed values on the s_ channel, one word per beat, with
//   s_tlast on the final word. Up to MAX_ITEMS words are kept; later words of
//   the same block are dropped and the block's overflow flag is set.
//   After the word with s_tlast, s_tready drops while the block is sorted in
//   place by quicksort (first element as pivot, two-index partition, range
//   stack in a small memory instead of recursion).
//   Then every kept word leaves on the m_ channel in ascending order; m_tlast
//   marks the largest and m_tuser carries the overflow flag on every word.
// Sequence:
//   Loading accepts one word per cycle. Each scan step of a partition goes
//   through the single read port of the element store (S_RDI then S_CHKI,
//   or S_RDJ then S_CHKJ), each swap through two writes and the loop test
//   (S_SWI, S_SWJ, S_OUTER), each partition through S_POP, S_POPW, S_PIVR,
//   S_PIVL, S_FINA, S_FINB, S_PUSHL and S_PUSHR. Each emitted word passes
//   through S_EMRD and S_EMLD.
// Reset and stall:
//   aresetn (synchronous, active low) empties the block and clears m_tvalid.
//   A stalled receiver holds the output word and pauses emission; loading of
//   the next block starts while the last sorted word still waits on m_.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_block_sorter_core #(
    parameter  int MAX_ITEMS   = qsbs_pkg::MAX_ITEMS_DEF,
    parameter  int VALUE_WIDTH = qsbs_pkg::VALUE_WIDTH_DEF,
    localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
    input  wire logic               s_tlast,   // last_item
    // sorted words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [VALUE_WIDTH-1:0] sorted_value
    output logic                    m_tlast,   // last_out
    output logic                    m_tuser    // [0] overflow
);

    qsbs_pkg::cmd_t         cmd;
    qsbs_pkg::sts_t         sts;
    logic [VALUE_WIDTH-1:0] out_value;

    // Sequence load, partition passes and emission
    qsbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_last  (s_tlast),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the block, the range stack and the output word
    qsbs_dpath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .m_ready   (m_tready),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

    // Zero-fill the word up to whole bytes
    assign m_tdata = TDATA_W'(out_value);

endmodule

`default_nettype wire

// ----- design/qsbs_checker.sv -----
// ----------------------------------------------------------------------------
// qsbs_checker
// Port-level checks of the block sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qsbs_checker #(
    parameter int TDATA_W = 32
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tlast,
    input wire logic               m_tuser
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output word changed while stalled");

    // Block end stops input for the sort
    a_stop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after block end");

    // Mid-block words keep the input open
    a_keep_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> s_tready)
        else $error("input closed inside a block");

    // New output words come only from the emit phase
    a_emit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output word appeared during loading");

endmodule

bind quicksort_block_sorter_core qsbs_checker #(
    .TDATA_W (TDATA_W)
) u_qsbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
